// ----- src/dcpq_pkg.sv -----
package dcpq_pkg;

	localparam int unsigned TAG_BITS = 8;

	// operation codes
	localparam logic [1:0] OP_ENQ     = 2'd0;
	localparam logic [1:0] OP_DEQ     = 2'd1;
	localparam logic [1:0] OP_DEQ_ANY = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOTHING = 2'd2;

	typedef struct packed {
		logic [1:0]          operation;
		logic                queue_class;
		logic [TAG_BITS-1:0] tag_in;
	} req_word_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [TAG_BITS-1:0] tag_out;
		logic                served_class;
	} rsp_word_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_sts_t;

endpackage

// ----- src/dual_class_priority_queue_top.sv -----
// path: a request word accepted is held in the input register (word_s1); when the response side can
// advance, its result is loaded into the result register (rsp_q) and rsp_valid rises
// throughput: one operation per cycle; the input stalls only while a response word waits
// each queue's head slot is kept in a register refreshed every cycle at the next read pointer
// reset: arst_n clears pipeline valids, read pointers and fill counts, and sets
// the preferred class (pref_q) to class 1; slot memories are not cleared
module dual_class_priority_queue_top #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TAG_WIDTH   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_data,
	input  logic                req_valid,
	output logic                req_stall,
	input  dcpq_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dcpq_pkg::rsp_word_t rsp
);

	localparam int unsigned TB     = dcpq_pkg::TAG_BITS;
	localparam int unsigned STORE_W = (TAG_WIDTH < TB) ? TAG_WIDTH : TB;
	localparam logic [TB-1:0] TagMask = (TAG_WIDTH >= TB) ? {TB{1'b1}} :
		TB'((64'd1 << TAG_WIDTH) - 64'd1);

	logic                pref_q;
	logic                valid_s1;
	dcpq_pkg::req_word_t word_s1;
	logic                rsp_valid_q;
	dcpq_pkg::rsp_word_t rsp_q;

	logic                advance;
	logic                do_step;
	dcpq_pkg::rsp_word_t result;

	dcpq_pkg::fifo_ctl_t ctl [2];
	dcpq_pkg::fifo_sts_t sts [2];
	logic [STORE_W-1:0]  head [2];

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign do_step   = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	for (genvar c = 0; c < 2; c++) begin : g_class
		dcpq_fifo #(
			.DEPTH(QUEUE_DEPTH),
			.WIDTH(STORE_W)
		) u_fifo (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl[c]),
			.wdata (word_s1.tag_in[STORE_W-1:0]),
			.head  (head[c]),
			.sts   (sts[c])
		);
	end

	always_comb begin
		logic cls;
		logic first;
		cls   = word_s1.queue_class;
		first = pref_q;
		for (int i = 0; i < 2; i++) begin
			ctl[i] = '0;
		end
		result.status       = dcpq_pkg::ST_NOTHING;
		result.tag_out      = '0;
		result.served_class = 1'b0;
		unique case (word_s1.operation)
			dcpq_pkg::OP_ENQ: begin
				result.served_class = cls;
				result.tag_out      = word_s1.tag_in & TagMask;
				if (sts[cls].full) begin
					result.status = dcpq_pkg::ST_FULL;
				end else begin
					result.status = dcpq_pkg::ST_OK;
					ctl[cls].push = do_step;
				end
			end
			dcpq_pkg::OP_DEQ: begin
				result.served_class = cls;
				if (!sts[cls].empty) begin
					result.status  = dcpq_pkg::ST_OK;
					result.tag_out = TB'(head[cls]);
					ctl[cls].pop   = do_step;
				end
			end
			dcpq_pkg::OP_DEQ_ANY: begin
				result.served_class = first;
				priority if (!sts[first].empty) begin
					result.status  = dcpq_pkg::ST_OK;
					result.tag_out = TB'(head[first]);
					ctl[first].pop = do_step;
				end else if (!sts[!first].empty) begin
					result.status       = dcpq_pkg::ST_OK;
					result.tag_out      = TB'(head[!first]);
					result.served_class = !first;
					ctl[!first].pop     = do_step;
				end else begin
					result.status = dcpq_pkg::ST_NOTHING;
				end
			end
			default: begin
				result.status = dcpq_pkg::ST_NOTHING;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pref_q      <= 1'b1;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pref_q <= cfg_data;
			end
			if (!valid_s1 || advance) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s1 || advance) begin
			word_s1 <= req;
		end
		if (do_step) begin
			rsp_q <= result;
		end
	end

endmodule

// ----- src/dcpq_fifo.sv -----
module dcpq_fifo #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dcpq_pkg::fifo_ctl_t ctl,
	input  logic [WIDTH-1:0]    wdata,
	output logic [WIDTH-1:0]    head,
	output dcpq_pkg::fifo_sts_t sts
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] head_q;
	logic [AW-1:0]    rd_q;
	logic [FW-1:0]    fill_q;

	logic [AW:0]   sum;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_inc;
	logic [AW-1:0] rd_next;

	// tail slot: read pointer plus fill, wrapped once
	assign sum     = {1'b0, rd_q} + (AW + 1)'(fill_q);
	assign wr_addr = (sum >= (AW + 1)'(DEPTH)) ? AW'(sum - (AW + 1)'(DEPTH)) : sum[AW-1:0];
	assign rd_inc  = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
	assign rd_next = ctl.pop ? rd_inc : rd_q;

	assign sts.full  = (fill_q == FW'(DEPTH));
	assign sts.empty = (fill_q == '0);
	assign head      = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			fill_q <= fill_q + 1'b1;
		end else if (ctl.pop) begin
			rd_q   <= rd_inc;
			fill_q <= fill_q - 1'b1;
		end
	end

	// head register always holds the slot at the read pointer; bypass the write
	// when a word lands right at the head (push into an empty queue)
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[wr_addr] <= wdata;
		end
		if (ctl.push && (wr_addr == rd_next)) begin
			head_q <= wdata;
		end else begin
			head_q <= mem[rd_next];
		end
	end

endmodule
